@@ rtl/dxtd_pkg.sv @@
// Shared types, codes and helpers for the DXT block decoder.
package dxtd_pkg;

  // Block format codes held in the format register.
  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;

  // Divisor selection for one channel numerator.
  typedef logic [2:0] div_sel_t;
  localparam div_sel_t DIV_ONE   = 3'd0;
  localparam div_sel_t DIV_TWO   = 3'd1;
  localparam div_sel_t DIV_THREE = 3'd2;
  localparam div_sel_t DIV_FIVE  = 3'd3;
  localparam div_sel_t DIV_SEVEN = 3'd4;

  // Reciprocals scaled by 2^15; exact for every numerator the palettes produce.
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [13:0] RECIP_THREE = 14'd10928;
  localparam logic [13:0] RECIP_FIVE  = 14'd6554;
  localparam logic [13:0] RECIP_SEVEN = 14'd4682;

  // One channel on its way to the divider: numerator and divisor code.
  typedef struct packed {
    logic [10:0] num;
    div_sel_t    div;
  } chan_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // RGB565 to RGB888 by shifting only, low bits left at zero.
  function automatic rgb_t expand_565(input logic [15:0] c);
    rgb_t p;
    p.r = {c[15:11], 3'b000};
    p.g = {c[10:5], 2'b00};
    p.b = {c[4:0], 3'b000};
    return p;
  endfunction

endpackage

@@ rtl/dxt_block_decoder_core.sv @@
// Top level of the DXT1/DXT3/DXT5 4x4 block decoder.
//
//   channel  ports                              handshake
//   -------  ---------------------------------  --------------------------------------
//   input    in_first_half, in_second_half      taken when start is high and busy low
//   result   out_pixel_index .. out_last_pixel  out_valid strobe, one pixel per cycle
//   config   cfg_data (block format)            cfg_valid and cfg_ready (always ready)
//
// Each item (one compressed block) yields sixteen pixels, one per cycle; the
// issue counter that walks the pixels paces the blocks. busy falls while the
// sixteenth pixel issues, so blocks stream without a gap. The first pixel
// passes the issue stage, stage 1 and stage 2, and stage 3 registers it onto
// the result ports.
// The receiver cannot stall: every pixel shows on the result ports for exactly
// one cycle. Reset is synchronous and clears the format to DXT1 and all valid bits.
module dxt_block_decoder_core
  import dxtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_first_half,
  input  logic [63:0] in_second_half,
  output logic        out_valid,
  output logic [3:0]  out_pixel_index,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_last_pixel,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  // Format register; only written while the block is idle, a user rule, unchecked.
  logic [1:0] fmt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_DXT1;
    end else if (cfg_valid) begin
      fmt_r <= cfg_data;
    end
  end

  // Issue stage: holds the block and walks the sixteen pixel positions.
  logic        act_r, act_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] blk_lo_r, blk_hi_r;
  logic [1:0]  blk_fmt_r;
  logic        accept;

  assign busy   = act_r && (cnt_r != 4'd15);
  assign accept = start && !busy;

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      act_nxt = 1'b1;
      cnt_nxt = 4'd0;
    end else if (act_r) begin
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'd15) begin
        act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= 4'd0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      blk_lo_r  <= in_first_half;
      blk_hi_r  <= in_second_half;
      blk_fmt_r <= fmt_r;
    end
  end

  // Per-pixel field extraction from the held block.
  logic        a_is_dxt1, a_is_dxt3;
  logic [63:0] a_cblk;
  logic [31:0] a_cidx_bits;
  logic [47:0] a_aidx_bits;
  logic [5:0]  a_aidx_pos;
  logic [1:0]  a_ci;
  logic [2:0]  a_aidx;
  logic [3:0]  a_nib;

  assign a_is_dxt1   = (blk_fmt_r == FMT_DXT1);
  assign a_is_dxt3   = (blk_fmt_r == FMT_DXT3);
  assign a_cblk      = a_is_dxt1 ? blk_lo_r : blk_hi_r;
  assign a_cidx_bits = a_cblk[63:32];
  assign a_ci        = a_cidx_bits[{cnt_r, 1'b0} +: 2];
  assign a_nib       = blk_lo_r[{cnt_r, 2'b00} +: 4];
  assign a_aidx_bits = blk_lo_r[63:16];
  assign a_aidx_pos  = {1'b0, cnt_r, 1'b0} + {2'b00, cnt_r};
  assign a_aidx      = a_aidx_bits[a_aidx_pos +: 3];

  // Stage 1: raw endpoints, indices and alpha fields for one pixel.
  logic        s1_vld_r;
  logic [3:0]  s1_pix_r;
  logic        s1_last_r;
  logic [15:0] s1_c0_r, s1_c1_r;
  logic [1:0]  s1_ci_r;
  logic        s1_four_r;
  logic        s1_dxt1_r, s1_dxt3_r;
  logic [3:0]  s1_nib_r;
  logic [7:0]  s1_a0_r, s1_a1_r;
  logic [2:0]  s1_aidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    if (act_r) begin
      s1_pix_r  <= cnt_r;
      s1_last_r <= (cnt_r == 4'd15);
      s1_c0_r   <= a_cblk[15:0];
      s1_c1_r   <= a_cblk[31:16];
      s1_ci_r   <= a_ci;
      // DXT3 and DXT5 always use four colors; DXT1 picks by endpoint order.
      s1_four_r <= !a_is_dxt1 || (a_cblk[15:0] > a_cblk[31:16]);
      s1_dxt1_r <= a_is_dxt1;
      s1_dxt3_r <= a_is_dxt3;
      s1_nib_r  <= a_nib;
      s1_a0_r   <= blk_lo_r[7:0];
      s1_a1_r   <= blk_lo_r[15:8];
      s1_aidx_r <= a_aidx;
    end
  end

  // Stage 2: numerators and divisor codes for the four channels.
  function automatic chan_t color_chan(input logic [7:0] v0, input logic [7:0] v1,
                                       input logic [1:0] ci, input logic four);
    chan_t c;
    c.div = DIV_ONE;
    c.num = 11'd0;
    case (ci)
      2'd0: c.num = 11'(v0);
      2'd1: c.num = 11'(v1);
      2'd2: begin
        if (four) begin
          c.num = {2'b00, v0, 1'b0} + 11'(v1);
          c.div = DIV_THREE;
        end else begin
          c.num = 11'(v0) + 11'(v1);
          c.div = DIV_TWO;
        end
      end
      default: begin
        if (four) begin
          c.num = 11'(v0) + {2'b00, v1, 1'b0};
          c.div = DIV_THREE;
        end
      end
    endcase
    return c;
  endfunction

  rgb_t  b_p0, b_p1;
  chan_t b_r, b_g, b_b, b_a;

  assign b_p0 = expand_565(s1_c0_r);
  assign b_p1 = expand_565(s1_c1_r);
  assign b_r  = color_chan(b_p0.r, b_p1.r, s1_ci_r, s1_four_r);
  assign b_g  = color_chan(b_p0.g, b_p1.g, s1_ci_r, s1_four_r);
  assign b_b  = color_chan(b_p0.b, b_p1.b, s1_ci_r, s1_four_r);

  always_comb begin
    logic [2:0] w0;
    logic [2:0] w1;
    w0 = 3'd0;
    w1 = 3'd0;
    b_a.div = DIV_ONE;
    b_a.num = 11'd255;
    if (s1_dxt1_r) begin
      // The transparent entry of the three-color palette has zero alpha.
      if (!s1_four_r && s1_ci_r == 2'd3) begin
        b_a.num = 11'd0;
      end
    end else if (s1_dxt3_r) begin
      b_a.num = {3'b000, s1_nib_r, s1_nib_r};
    end else if (s1_aidx_r == 3'd0) begin
      b_a.num = 11'(s1_a0_r);
    end else if (s1_aidx_r == 3'd1) begin
      b_a.num = 11'(s1_a1_r);
    end else if (s1_a0_r > s1_a1_r) begin
      w0      = 3'(4'd8 - 4'(s1_aidx_r));
      w1      = s1_aidx_r - 3'd1;
      b_a.num = 11'(w0) * 11'(s1_a0_r) + 11'(w1) * 11'(s1_a1_r);
      b_a.div = DIV_SEVEN;
    end else if (s1_aidx_r == 3'd6) begin
      b_a.num = 11'd0;
    end else if (s1_aidx_r == 3'd7) begin
      b_a.num = 11'd255;
    end else begin
      w0      = 3'd6 - s1_aidx_r;
      w1      = s1_aidx_r - 3'd1;
      b_a.num = 11'(w0) * 11'(s1_a0_r) + 11'(w1) * 11'(s1_a1_r);
      b_a.div = DIV_FIVE;
    end
  end

  logic       s2_vld_r;
  logic [3:0] s2_pix_r;
  logic       s2_last_r;
  chan_t      s2_r_r, s2_g_r, s2_b_r, s2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      s2_pix_r  <= s1_pix_r;
      s2_last_r <= s1_last_r;
      s2_r_r    <= b_r;
      s2_g_r    <= b_g;
      s2_b_r    <= b_b;
      s2_a_r    <= b_a;
    end
  end

  // Stage 3: divide each channel and register the result item.
  logic [7:0] c_r, c_g, c_b, c_a;

  dxtd_div u_div_r (.ch(s2_r_r), .quot(c_r));
  dxtd_div u_div_g (.ch(s2_g_r), .quot(c_g));
  dxtd_div u_div_b (.ch(s2_b_r), .quot(c_b));
  dxtd_div u_div_a (.ch(s2_a_r), .quot(c_a));

  logic       out_vld_r;
  logic [3:0] out_pix_r;
  logic       out_last_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      out_pix_r   <= s2_pix_r;
      out_last_r  <= s2_last_r;
      out_red_r   <= c_r;
      out_green_r <= c_g;
      out_blue_r  <= c_b;
      out_alpha_r <= c_a;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_pixel_index = out_pix_r;
  assign out_last_pixel  = out_last_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_alpha       = out_alpha_r;

  // A taken item reaches stage 1 with pixel zero by way of the issue registers.
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 (s1_vld_r && s1_pix_r == 4'd0))
    else $error("accepted item did not enter stage 1 at pixel zero");

  // Pixels of one item leave back to back in raster order.
  a_pixel_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_pixel) |=>
      (out_valid && out_pixel_index == $past(out_pixel_index) + 4'd1))
    else $error("pixel run broken or out of order");

  // The last-pixel flag marks the sixteenth pixel and no other.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_pixel == (out_pixel_index == 4'd15)))
    else $error("last_pixel flag disagrees with pixel index");

endmodule

@@ rtl/dxtd_div.sv @@
// Truncating divide of a small number by 1, 2, 3, 5 or 7; 3, 5, 7 by reciprocal multiply.
module dxtd_div
  import dxtd_pkg::*;
(
  input  chan_t      ch,
  output logic [7:0] quot
);

  logic [13:0] recip;
  logic [24:0] prod;

  always_comb begin
    unique case (ch.div)
      DIV_FIVE:  recip = RECIP_FIVE;
      DIV_SEVEN: recip = RECIP_SEVEN;
      default:   recip = RECIP_THREE;
    endcase
  end

  assign prod = 25'(ch.num) * 25'(recip);

  always_comb begin
    unique case (ch.div)
      DIV_ONE:   quot = ch.num[7:0];
      DIV_TWO:   quot = ch.num[8:1];
      DIV_THREE,
      DIV_FIVE,
      DIV_SEVEN: quot = prod[RECIP_SHIFT+7:RECIP_SHIFT];
      default:   quot = ch.num[7:0];
    endcase
  end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the DXT1/DXT3/DXT5 block decoder core.
`timescale 1ns / 100ps

module tb;
  import dxtd_pkg::*;

  // Format codes beyond the two that the package names. The top code is
  // unused by the format and is expected to decode exactly like DXT5.
  localparam logic [1:0] FMT_DXT5     = 2'd2;
  localparam logic [1:0] FMT_RESERVED = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 80;
  localparam int REPORT_MAX   = 10;

  // One decoded pixel, as it shows on the result ports.
  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pixel_t;

  // One row of the directed table. Where has_rgba is set, every pixel of the
  // block is known to decode to the color in rgba (red in the top byte).
  typedef struct packed {
    logic [1:0]  fmt;
    logic [63:0] first;
    logic [63:0] second;
    logic        has_rgba;
    logic [31:0] rgba;
  } block_row_t;

  localparam int NUM_ROWS = 20;
  localparam block_row_t DIRECTED_BLOCKS [NUM_ROWS] = '{
    // DXT1: equal black endpoints select the three-color palette; index 0.
    '{FMT_DXT1, 64'h0, 64'h0, 1'b1, 32'h000000FF},
    // DXT1: white over black, four-color palette, index 0 (second half ignored).
    '{FMT_DXT1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hF8FCF8FF},
    // DXT1: black over white, three-color palette, index 3 is transparent.
    '{FMT_DXT1, 64'hFFFF_FFFF_FFFF_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'h00000000},
    '{FMT_DXT1, 64'hE4E4_E4E4_001F_F800, 64'h0, 1'b0, 32'h0},
    '{FMT_DXT1, 64'hE4E4_E4E4_F800_001F, 64'h0, 1'b0, 32'h0},
    '{FMT_DXT1, 64'h1B1B_1B1B_07E0_07E0, 64'h0, 1'b0, 32'h0},
    '{FMT_DXT1, 64'hE4E4_E4E4_0000_FFFF, 64'h0, 1'b0, 32'h0},
    // DXT3: explicit alpha all ones and all zeros over a black color block.
    '{FMT_DXT3, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, 32'h000000FF},
    '{FMT_DXT3, 64'h0, 64'h0, 1'b1, 32'h00000000},
    '{FMT_DXT3, 64'hFEDC_BA98_7654_3210, 64'hE4E4_E4E4_0000_FFFF, 1'b0, 32'h0},
    // DXT3 keeps the four-color palette even when endpoint0 is not larger.
    '{FMT_DXT3, 64'h0123_4567_89AB_CDEF, 64'hE4E4_E4E4_FFFF_0000, 1'b0, 32'h0},
    // DXT5: equal alphas, index 7 gives full alpha and index 6 gives zero.
    '{FMT_DXT5, 64'hFFFF_FFFF_FFFF_8080, 64'h0, 1'b1, 32'h000000FF},
    '{FMT_DXT5, 64'hDB6D_B6DB_6DB6_8080, 64'h0, 1'b1, 32'h00000000},
    // DXT5: index 0 picks alpha0; white endpoints at color index 3.
    '{FMT_DXT5, 64'h0000_0000_0000_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hF8FCF8FF},
    // DXT5: alpha indices walk 0..7 under both alpha palette modes.
    '{FMT_DXT5, 64'hFAC6_88FA_C688_00FF, 64'hE4E4_E4E4_001F_F800, 1'b0, 32'h0},
    '{FMT_DXT5, 64'hFAC6_88FA_C688_FF00, 64'hE4E4_E4E4_001F_F800, 1'b0, 32'h0},
    '{FMT_DXT5, 64'hFAC6_88FA_C688_3CC3, 64'hE4E4_E4E4_F800_001F, 1'b0, 32'h0},
    // The unused format code behaves as DXT5.
    '{FMT_RESERVED, 64'hFAC6_88FA_C688_2080, 64'h1B1B_1B1B_07FF_F81F, 1'b0, 32'h0},
    '{FMT_RESERVED, 64'hFFFF_FFFF_FFFF_8080, 64'h0, 1'b1, 32'h000000FF},
    // Back to DXT1 from the top code.
    '{FMT_DXT1, 64'hE4E4_E4E4_001F_F800, 64'h0123_4567_89AB_CDEF, 1'b0, 32'h0}
  };

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [63:0] in_first_half  = '0;
  logic [63:0] in_second_half = '0;
  logic        cfg_valid      = 1'b0;
  logic [1:0]  cfg_data       = '0;
  logic        busy;
  logic        out_valid;
  logic [3:0]  out_pixel_index;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_last_pixel;
  logic        cfg_ready;

  // Our copy of the format register, updated on each accepted write.
  logic [1:0] format_shadow = FMT_DXT1;
  // Pixels still owed by the block, oldest first.
  pixel_t     pending_pixels [$];
  int         mismatches = 0;
  int         cycles     = 0;
  // While set, the sender never leaves a gap between items.
  bit         steady     = 1'b0;

  dxt_block_decoder_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_first_half   (in_first_half),
    .in_second_half  (in_second_half),
    .out_valid       (out_valid),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_alpha       (out_alpha),
    .out_last_pixel  (out_last_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Decodes one block under the given format and queues its sixteen pixels.
  // The color block comes from the first half in DXT1 and from the second
  // half otherwise. Endpoints expand by shifting only, and every palette
  // division truncates.
  function automatic void decode_block(input logic [1:0] fmt, input logic [63:0] first,
                                       input logic [63:0] second);
    logic [63:0] cblk;
    logic [15:0] ep [2];
    logic [7:0]  pr [4];
    logic [7:0]  pg [4];
    logic [7:0]  pb [4];
    logic [7:0]  pa [4];
    logic [7:0]  ap [8];
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [1:0]  ci;
    pixel_t      px;
    cblk  = (fmt == FMT_DXT1) ? first : second;
    ep[0] = cblk[15:0];
    ep[1] = cblk[31:16];
    for (int k = 0; k < 2; k++) begin
      pr[k] = 8'((ep[k] & 16'hF800) >> 8);
      pg[k] = 8'((ep[k] & 16'h07E0) >> 3);
      pb[k] = 8'((ep[k] & 16'h001F) << 3);
      pa[k] = 8'hFF;
    end
    // Only DXT1 may fall back to three colors plus transparent black, and
    // only when endpoint0 is not above endpoint1 as a raw 16-bit value.
    if (fmt != FMT_DXT1 || ep[0] > ep[1]) begin
      pr[2] = 8'((2 * pr[0] + pr[1]) / 3);
      pg[2] = 8'((2 * pg[0] + pg[1]) / 3);
      pb[2] = 8'((2 * pb[0] + pb[1]) / 3);
      pr[3] = 8'((pr[0] + 2 * pr[1]) / 3);
      pg[3] = 8'((pg[0] + 2 * pg[1]) / 3);
      pb[3] = 8'((pb[0] + 2 * pb[1]) / 3);
      pa[3] = 8'hFF;
    end else begin
      pr[2] = 8'((pr[0] + pr[1]) / 2);
      pg[2] = 8'((pg[0] + pg[1]) / 2);
      pb[2] = 8'((pb[0] + pb[1]) / 2);
      pr[3] = 8'h00;
      pg[3] = 8'h00;
      pb[3] = 8'h00;
      pa[3] = 8'h00;
    end
    pa[2] = 8'hFF;
    // Interpolated alpha palette: eight steps when alpha0 is larger, else
    // six steps plus fixed zero and full alpha.
    a0    = first[7:0];
    a1    = first[15:8];
    ap[0] = a0;
    ap[1] = a1;
    if (a0 > a1) begin
      for (int k = 2; k < 8; k++) ap[k] = 8'(((8 - k) * a0 + (k - 1) * a1) / 7);
    end else begin
      for (int k = 2; k < 6; k++) ap[k] = 8'(((6 - k) * a0 + (k - 1) * a1) / 5);
      ap[6] = 8'h00;
      ap[7] = 8'hFF;
    end
    for (int i = 0; i < 16; i++) begin
      ci      = cblk[32 + 2 * i +: 2];
      px.idx  = i[3:0];
      px.r    = pr[ci];
      px.g    = pg[ci];
      px.b    = pb[ci];
      px.a    = pa[ci];
      px.last = (i == 15);
      if (fmt == FMT_DXT3) begin
        px.a = first[4 * i +: 4] * 8'h11;
      end else if (fmt[1]) begin
        // The high bit of the code selects interpolated alpha, so the
        // unused top code lands here too.
        px.a = ap[first[16 + 3 * i +: 3]];
      end
      pending_pixels.push_back(px);
    end
  endfunction

  // Presents one block and returns at the edge that takes it. Outside the
  // steady stretch it may idle first; each idle step is taken with a chance of 13 in 100.
  task automatic send_block(input logic [63:0] first, input logic [63:0] second);
    while (!steady && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_first_half  <= first;
    in_second_half <= second;
    do @(posedge clk); while (busy);
  endtask

  // Changes the format once the decoder has gone quiet. Every block owes
  // pixels, so an empty queue means no block is in flight; the short pause
  // covers the pipeline's tail after the last pixel.
  task automatic set_format(input logic [1:0] fmt);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= fmt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid     <= 1'b0;
    format_shadow  = fmt;
  endtask

  // Result checker. Pixels are sampled at the edge that ends their cycle,
  // before the decoder's own updates at that edge take effect.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel: idx=%0d rgba=%02h%02h%02h%02h last=%0b",
                   out_pixel_index, out_red, out_green, out_blue, out_alpha,
                   out_last_pixel);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_index !== want.idx || out_red !== want.r || out_green !== want.g ||
            out_blue !== want.b || out_alpha !== want.a || out_last_pixel !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("pixel mismatch: expected idx=%0d rgba=%02h%02h%02h%02h last=%0b",
                     want.idx, want.r, want.g, want.b, want.a, want.last);
            $display("                got      idx=%0d rgba=%02h%02h%02h%02h last=%0b",
                     out_pixel_index, out_red, out_green, out_blue, out_alpha,
                     out_last_pixel);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost pixel ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pixel_t      px;
    logic [1:0]  fmt;
    logic [63:0] first;
    logic [63:0] second;
    int          sent;
    int          phase;
    int          phase_len;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blocks. The format register is rewritten whenever the table
    // moves to a new format, which walks it through every code.
    for (int row = 0; row < NUM_ROWS; row++) begin
      if (DIRECTED_BLOCKS[row].fmt != format_shadow) set_format(DIRECTED_BLOCKS[row].fmt);
      send_block(DIRECTED_BLOCKS[row].first, DIRECTED_BLOCKS[row].second);
      if (DIRECTED_BLOCKS[row].has_rgba) begin
        for (int i = 0; i < 16; i++) begin
          px.idx  = i[3:0];
          px.r    = DIRECTED_BLOCKS[row].rgba[31:24];
          px.g    = DIRECTED_BLOCKS[row].rgba[23:16];
          px.b    = DIRECTED_BLOCKS[row].rgba[15:8];
          px.a    = DIRECTED_BLOCKS[row].rgba[7:0];
          px.last = (i == 15);
          pending_pixels.push_back(px);
        end
      end else begin
        decode_block(format_shadow, DIRECTED_BLOCKS[row].first,
                     DIRECTED_BLOCKS[row].second);
      end
    end

    // Random blocks in phases, each under a randomly chosen format. The
    // third phase runs with no sender gaps at all, so blocks stream back to
    // back. Equal endpoints and equal alphas are forced now and then, since
    // plain random data almost never produces them.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      fmt = 2'($urandom_range(3));
      if (fmt != format_shadow) set_format(fmt);
      steady    = (phase == 2);
      phase_len = $urandom_range(6, 20);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        first  = {$urandom, $urandom};
        second = {$urandom, $urandom};
        if ($urandom_range(5) == 0) begin
          if (format_shadow == FMT_DXT1) first[31:16] = first[15:0];
          else second[31:16] = second[15:0];
        end
        if ($urandom_range(5) == 0) first[15:8] = first[7:0];
        send_block(first, second);
        decode_block(format_shadow, first, second);
        sent++;
      end
      phase++;
    end
    steady = 1'b0;

    // Drain: wait for the last owed pixel, then watch a little longer for
    // any stray output.
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dxtd_pkg.sv
rtl/dxtd_div.sv
rtl/dxt_block_decoder_core.sv
verif/tb.sv
